FILE: src/lscp_pkg.sv
// shared types, constants and functions of the layered slab color predictor
package lscp_pkg;

    localparam int unsigned DEF_MAX_LAYERS    = 8;
    localparam int unsigned DEF_MAX_MATERIALS = 64;
    localparam int unsigned DEF_FRAC_BITS     = 16;

    localparam int unsigned NCH        = 3;
    localparam int unsigned MAT_W      = 6;
    localparam int unsigned CH_W       = 2;
    localparam int unsigned IN_VAL_W   = 17;
    localparam int unsigned SEQ_W      = 48;
    localparam int unsigned LCNT_W     = 4;
    localparam int unsigned MCNT_W     = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned OUT_W      = 16;
    localparam int unsigned VAL_W_MAX  = 25;

    localparam int unsigned ROM_SIZE   = 257;
    localparam int unsigned ROM_W      = 17;
    localparam logic [16:0] LIN_LIMIT  = 17'd205;
    localparam logic [19:0] LIN_GAIN   = 20'd846725;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT    = 3'd0,
        CFG_MATERIAL_COUNT = 3'd1,
        CFG_BOTTOM_FIRST   = 3'd2,
        CFG_BASE_RED       = 3'd3,
        CFG_BASE_GREEN     = 3'd4,
        CFG_BASE_BLUE      = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req_type;

    // control part of a word traveling down the cell chain
    typedef struct packed {
        logic                valid;
        logic                is_eval;
        logic                last;
        logic [MAT_W-1:0]    mat;
        logic [CH_W-1:0]     ch;
        logic [IN_VAL_W-1:0] refl;
        logic [IN_VAL_W-1:0] trans;
    } t_ctl;

    typedef logic [ROM_W-1:0] t_srgb_rom [ROM_SIZE];

    // keep frac+1 bits and clamp to one
    function automatic logic [VAL_W_MAX-1:0] sat_one(input logic [IN_VAL_W-1:0] v,
                                                     input int unsigned frac);
        logic [VAL_W_MAX-1:0] m;
        logic [VAL_W_MAX-1:0] one;
        m   = VAL_W_MAX'(v);
        m   = m & ((VAL_W_MAX'(1) << (frac + 1)) - VAL_W_MAX'(1));
        one = VAL_W_MAX'(1) << frac;
        return (m > one) ? one : m;
    endfunction

    // srgb curve samples, root by bisection on the twelfth power in q30
    function automatic t_srgb_rom build_srgb_rom();
        t_srgb_rom       rom;
        longint unsigned x, p, lo, hi, mid, a, num, sub, rem, dv;
        logic [ROM_W:0]  q;
        for (int k = 0; k < ROM_SIZE; k++) begin
            x = longint'(k) << 22;
            p = x;
            for (int i = 0; i < 4; i++) p = (p * x) >> 30;
            lo = 64'd0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                a = mid;
                for (int j = 0; j < 11; j++) a = (a * mid) >> 30;
                if (a <= p) lo = mid;
                else hi = mid - 64'd1;
            end
            num = 64'd1055 * lo * 64'd65536;
            sub = 64'd55 << 46;
            if (num <= sub) begin
                rom[k] = '0;
            end else begin
                // rounded quotient by 1000 << 30, long division msb first
                rem = num - sub + (64'd500 << 30);
                q   = '0;
                for (int b = ROM_W; b >= 0; b--) begin
                    dv = (64'd1000 << 30) << b;
                    if (rem >= dv) begin
                        rem  = rem - dv;
                        q[b] = 1'b1;
                    end
                end
                rom[k] = q[ROM_W-1:0];
            end
        end
        return rom;
    endfunction

endpackage

FILE: src/lscp_if.sv
// request and result channel interfaces
interface lscp_req_if import lscp_pkg::*;;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [MAT_W-1:0]    entry_material;
    logic [CH_W-1:0]     entry_channel;
    logic [IN_VAL_W-1:0] entry_reflect;
    logic [IN_VAL_W-1:0] entry_transmit;
    logic [SEQ_W-1:0]    layer_materials;
    logic                last_sequence;

    modport src (output valid, req_type, entry_material, entry_channel, entry_reflect,
                 entry_transmit, layer_materials, last_sequence, input ready);
    modport snk (input valid, req_type, entry_material, entry_channel, entry_reflect,
                 entry_transmit, layer_materials, last_sequence, output ready);
endinterface

interface lscp_res_if import lscp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             last_result;

    modport src (output valid, red_out, green_out, blue_out, last_result, input ready);
    modport snk (input valid, red_out, green_out, blue_out, last_result, output ready);
endinterface

FILE: src/lscp_cell.sv
// one layer cell: local material table, adding step with pipelined divider
module lscp_cell import lscp_pkg::*; #(
    parameter int unsigned MAX_LAYERS    = DEF_MAX_LAYERS,
    parameter int unsigned MAX_MATERIALS = DEF_MAX_MATERIALS,
    parameter int unsigned FRAC_BITS     = DEF_FRAC_BITS,
    parameter int unsigned LAYER         = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  t_ctl                              i_ctl,
    input  logic [MAX_LAYERS-1:0][MAT_W-1:0]  i_mats,
    input  logic [MAX_LAYERS-1:0]             i_act,
    input  logic [FRAC_BITS:0]                i_refl [NCH],
    output t_ctl                              o_ctl,
    output logic [MAX_LAYERS-1:0][MAT_W-1:0]  o_mats,
    output logic [MAX_LAYERS-1:0]             o_act,
    output logic [FRAC_BITS:0]                o_refl [NCH]
);

    localparam int unsigned W  = FRAC_BITS + 1;
    localparam int unsigned AW = $clog2(MAX_MATERIALS);
    localparam int unsigned NS = W + 5;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    t_ctl                             r_ctl  [NS];
    logic [MAX_LAYERS-1:0][MAT_W-1:0] r_mats [NS];
    logic [MAX_LAYERS-1:0]            r_act  [NS];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [2*W-1:0] wr_data;
    logic          fin_act;

    // table writes happen as the load word passes, so order with evaluates holds
    assign wr_en   = i_ctl.valid && !i_ctl.is_eval
                     && ({1'b0, i_ctl.mat} < MCNT_W'(MAX_MATERIALS))
                     && (i_ctl.ch < CH_W'(NCH));
    assign wr_addr = i_ctl.mat[AW-1:0];
    assign wr_data = {W'(sat_one(i_ctl.trans, FRAC_BITS)), W'(sat_one(i_ctl.refl, FRAC_BITS))};
    assign rd_addr = i_mats[LAYER][AW-1:0];
    assign fin_act = r_ctl[NS-2].is_eval && r_act[NS-2][LAYER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_ctl[s].valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < NS; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mats[0] <= i_mats;
            r_act[0]  <= i_act;
            for (int s = 1; s < NS; s++) begin
                r_mats[s] <= r_mats[s-1];
                r_act[s]  <= r_act[s-1];
            end
        end
    end

    assign o_ctl  = r_ctl[NS-1];
    assign o_mats = r_mats[NS-1];
    assign o_act  = r_act[NS-1];

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [2*W-1:0] mem [MAX_MATERIALS];
        logic [2*W-1:0] r_rd;
        logic [W-1:0]   r_refl1;
        logic [W-1:0]   rd_r;
        logic [W-1:0]   rd_t;
        logic [2*W-1:0] prr;
        logic [2*W-1:0] ptt;
        logic [2*W-1:0] r_prr;
        logic [2*W-1:0] r_ptt;
        logic [W-1:0]   r_r2;
        logic [W-1:0]   r_refl2;
        logic [W-1:0]   den_raw;
        logic [W-1:0]   den;
        logic [W-1:0]   tt;
        logic [2*W-1:0] num;
        logic [W-1:0]   r_den3;
        logic [2*W-1:0] r_num3;
        logic [W-1:0]   r_r3;
        logic [W-1:0]   r_refl3;
        logic [W-1:0]   r_rem  [W+1];
        logic [W-1:0]   r_low  [W+1];
        logic [W-1:0]   r_q    [W+1];
        logic [W-1:0]   r_dv   [W+1];
        logic [W-1:0]   r_rv   [W+1];
        logic [W-1:0]   r_reflv[W+1];
        logic           r_sat  [W+1];
        logic [W:0]     sum;
        logic [W-1:0]   new_refl;
        logic [W-1:0]   r_out;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (wr_en && (i_ctl.ch == CH_W'(c))) mem[wr_addr] <= wr_data;
                r_rd    <= mem[rd_addr];
                r_refl1 <= i_refl[c];
            end
        end

        assign rd_r = r_rd[W-1:0];
        assign rd_t = r_rd[2*W-1:W];
        assign prr  = (2*W)'(rd_r) * (2*W)'(r_refl1);
        assign ptt  = (2*W)'(rd_t) * (2*W)'(rd_t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prr   <= prr;
                r_ptt   <= ptt;
                r_r2    <= rd_r;
                r_refl2 <= r_refl1;
            end
        end

        // denominator floored at one lsb
        assign den_raw = ONE - r_prr[FRAC_BITS +: W];
        assign den     = (den_raw == '0) ? W'(1) : den_raw;
        assign tt      = r_ptt[FRAC_BITS +: W];
        assign num     = (2*W)'(tt) * (2*W)'(r_refl2);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den3  <= den;
                r_num3  <= num;
                r_r3    <= r_r2;
                r_refl3 <= r_refl2;
            end
        end

        // a quotient wider than w bits clamps the sum anyway
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[0]   <= r_num3[2*W-1:W] >= r_den3;
                r_rem[0]   <= r_num3[2*W-1:W];
                r_low[0]   <= r_num3[W-1:0];
                r_q[0]     <= '0;
                r_dv[0]    <= r_den3;
                r_rv[0]    <= r_r3;
                r_reflv[0] <= r_refl3;
            end
        end

        for (genvar j = 0; j < W; j++) begin : g_div
            logic [W:0] trial;
            logic       ge;
            assign trial = {r_rem[j], r_low[j][W-1-j]};
            assign ge    = trial >= {1'b0, r_dv[j]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1]   <= ge ? W'(trial - {1'b0, r_dv[j]}) : W'(trial);
                    r_q[j+1]     <= {r_q[j][W-2:0], ge};
                    r_low[j+1]   <= r_low[j];
                    r_dv[j+1]    <= r_dv[j];
                    r_rv[j+1]    <= r_rv[j];
                    r_reflv[j+1] <= r_reflv[j];
                    r_sat[j+1]   <= r_sat[j];
                end
            end
        end

        assign sum      = (W+1)'(r_rv[W]) + (W+1)'(r_q[W]);
        assign new_refl = (r_sat[W] || (sum > (W+1)'(ONE))) ? ONE : sum[W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_out <= fin_act ? new_refl : r_reflv[W];
            end
        end

        assign o_refl[c] = r_out;
    end

endmodule

FILE: src/lscp_srgb.sv
// linear to srgb conversion, linear segment near zero, rom lookup with interpolation above it
module lscp_srgb import lscp_pkg::*; #(
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_last,
    input  logic [FRAC_BITS:0] i_refl [NCH],
    output logic             o_valid,
    output logic             o_last,
    output logic [OUT_W-1:0] o_rgb [NCH]
);

    localparam t_srgb_rom SRGB_ROM = build_srgb_rom();
    localparam logic [8:0] TOP_IDX = 9'(ROM_SIZE - 1);

    logic r_vb, r_vc, r_lb, r_lc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_vb <= i_valid;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lb <= i_last;
            r_lc <= r_lb;
        end
    end

    assign o_valid = r_vc;
    assign o_last  = r_lc;

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [16:0]      x;
        logic [8:0]       idx;
        logic [8:0]       nidx;
        logic [ROM_W-1:0] base;
        logic [ROM_W-1:0] nxt;
        logic             r_lin_b, r_lin_c;
        logic [7:0]       r_xl, r_frac;
        logic [ROM_W-1:0] r_base_b, r_base_c, r_diff;
        logic [27:0]      plin, r_plin;
        logic [24:0]      pint, r_pint;
        logic [17:0]      v;

        if (FRAC_BITS >= 16) begin : g_down
            assign x = 17'(i_refl[c] >> (FRAC_BITS - 16));
        end else begin : g_up
            assign x = 17'({i_refl[c], {(16 - FRAC_BITS){1'b0}}});
        end

        assign idx  = x[16:8];
        assign nidx = (idx == TOP_IDX) ? TOP_IDX : idx + 9'd1;
        assign base = SRGB_ROM[idx];
        assign nxt  = SRGB_ROM[nidx];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lin_b  <= x <= LIN_LIMIT;
                r_xl     <= x[7:0];
                r_frac   <= x[7:0];
                r_base_b <= base;
                r_diff   <= nxt - base;
            end
        end

        assign plin = 28'(r_xl) * 28'(LIN_GAIN);
        assign pint = 25'(r_diff) * 25'(r_frac);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lin_c  <= r_lin_b;
                r_plin   <= plin;
                r_pint   <= pint;
                r_base_c <= r_base_b;
            end
        end

        assign v = r_lin_c ? 18'((r_plin + 28'd32768) >> 16)
                           : 18'(r_base_c) + 18'((r_pint + 25'd128) >> 8);
        assign o_rgb[c] = (v > 18'd65535) ? 16'hFFFF : v[15:0];
    end

endmodule

FILE: src/layered_slab_color_predict_unit.sv
// top level: entry stage, chain of layer cells, srgb conversion, output register
// Takes one word per clock: load words write one table entry (material, channel), evaluate
// words carry up to eight 6-bit material indices and give one srgb triple. Every cell of
// the chain owns one layer position and its own copy of the material table, which a
// load word writes as it passes, so loads and evaluates keep their order. Throughput is
// one word per cycle while the pipe is not held; the restoring divider in each cell
// retires one quotient bit per stage. The whole pipe holds while the result register is
// full and not taken. Table entries have no reset and must be loaded before use.
// Configuration must be written by the user only while the unit is idle, which the unit
// itself does not enforce.
module layered_slab_color_predict_unit import lscp_pkg::*; #(
    parameter int unsigned MAX_LAYERS    = DEF_MAX_LAYERS,
    parameter int unsigned MAX_MATERIALS = DEF_MAX_MATERIALS,
    parameter int unsigned FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lscp_req_if.snk               i_req,
    lscp_res_if.src               o_res
);

    localparam int unsigned W  = FRAC_BITS + 1;
    localparam int unsigned LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    // configuration registers
    logic [LCNT_W-1:0]   r_layer_count;
    logic [MCNT_W-1:0]   r_mat_count;
    logic                r_bottom_first;
    logic [IN_VAL_W-1:0] r_base [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count  <= LCNT_W'(8);
            r_mat_count    <= MCNT_W'(64);
            r_bottom_first <= 1'b0;
            for (int c = 0; c < NCH; c++) r_base[c] <= IN_VAL_W'(32768);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LAYER_COUNT:    r_layer_count  <= i_cfg_data[LCNT_W-1:0];
                CFG_MATERIAL_COUNT: r_mat_count    <= i_cfg_data[MCNT_W-1:0];
                CFG_BOTTOM_FIRST:   r_bottom_first <= i_cfg_data[0];
                CFG_BASE_RED:       r_base[0]      <= i_cfg_data;
                CFG_BASE_GREEN:     r_base[1]      <= i_cfg_data;
                CFG_BASE_BLUE:      r_base[2]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: pipe moves unless the result register is stuck
    logic en, accept;
    logic r_out_valid;
    assign en          = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && en;
    assign i_req.ready = en;

    // layer count and material limit clamped to the build
    logic [LCNT_W-1:0] layer_n;
    logic [MCNT_W-1:0] limit;
    assign layer_n = (r_layer_count > LCNT_W'(MAX_LAYERS)) ? LCNT_W'(MAX_LAYERS) : r_layer_count;
    assign limit   = (r_mat_count > MCNT_W'(MAX_MATERIALS)) ? MCNT_W'(MAX_MATERIALS)
                                                             : r_mat_count;

    // slots past the 48-bit field read as material zero
    logic [MAT_W-1:0] slot_mat [MAX_LAYERS];
    for (genvar p = 0; p < MAX_LAYERS; p++) begin : g_slot
        if ((p + 1) * MAT_W <= SEQ_W) begin : g_in
            assign slot_mat[p] = i_req.layer_materials[p*MAT_W +: MAT_W];
        end else begin : g_out
            assign slot_mat[p] = '0;
        end
    end

    // cell k takes slot k, or the mirrored slot when bottom first
    logic [MAX_LAYERS-1:0][MAT_W-1:0] ent_mats;
    logic [MAX_LAYERS-1:0]            ent_act;
    for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_sel
        logic [LCNT_W-1:0] pos;
        assign pos = r_bottom_first ? (layer_n - LCNT_W'(1) - LCNT_W'(k)) : LCNT_W'(k);
        assign ent_mats[k] = (pos < LCNT_W'(MAX_LAYERS)) ? slot_mat[pos[LW-1:0]] : '0;
        assign ent_act[k]  = (LCNT_W'(k) < layer_n) && ({1'b0, ent_mats[k]} < limit);
    end

    // entry stage
    t_ctl                             r_ent_ctl;
    logic [MAX_LAYERS-1:0][MAT_W-1:0] r_ent_mats;
    logic [MAX_LAYERS-1:0]            r_ent_act;
    logic [W-1:0]                     r_ent_refl [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_ctl.valid <= 1'b0;
        end else if (en) begin
            r_ent_ctl.valid   <= accept;
            r_ent_ctl.is_eval <= i_req.req_type == REQ_EVAL;
            r_ent_ctl.last    <= i_req.last_sequence;
            r_ent_ctl.mat     <= i_req.entry_material;
            r_ent_ctl.ch      <= i_req.entry_channel;
            r_ent_ctl.refl    <= i_req.entry_reflect;
            r_ent_ctl.trans   <= i_req.entry_transmit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ent_mats <= ent_mats;
            r_ent_act  <= ent_act;
            for (int c = 0; c < NCH; c++) r_ent_refl[c] <= W'(sat_one(r_base[c], FRAC_BITS));
        end
    end

    // cell chain
    t_ctl                             ctl_ch  [MAX_LAYERS+1];
    logic [MAX_LAYERS-1:0][MAT_W-1:0] mats_ch [MAX_LAYERS+1];
    logic [MAX_LAYERS-1:0]            act_ch  [MAX_LAYERS+1];
    logic [W-1:0]                     refl_ch [MAX_LAYERS+1][NCH];

    assign ctl_ch[0]  = r_ent_ctl;
    assign mats_ch[0] = r_ent_mats;
    assign act_ch[0]  = r_ent_act;
    assign refl_ch[0] = r_ent_refl;

    for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_cell
        lscp_cell #(
            .MAX_LAYERS    (MAX_LAYERS),
            .MAX_MATERIALS (MAX_MATERIALS),
            .FRAC_BITS     (FRAC_BITS),
            .LAYER         (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_ch[k]),
            .i_mats  (mats_ch[k]),
            .i_act   (act_ch[k]),
            .i_refl  (refl_ch[k]),
            .o_ctl   (ctl_ch[k+1]),
            .o_mats  (mats_ch[k+1]),
            .o_act   (act_ch[k+1]),
            .o_refl  (refl_ch[k+1])
        );
    end

    // srgb conversion, only evaluate words go on
    logic             cv_valid, cv_last;
    logic [OUT_W-1:0] cv_rgb [NCH];

    lscp_srgb #(
        .FRAC_BITS (FRAC_BITS)
    ) u_srgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ctl_ch[MAX_LAYERS].valid && ctl_ch[MAX_LAYERS].is_eval),
        .i_last  (ctl_ch[MAX_LAYERS].last),
        .i_refl  (refl_ch[MAX_LAYERS]),
        .o_valid (cv_valid),
        .o_last  (cv_last),
        .o_rgb   (cv_rgb)
    );

    // result register
    logic [OUT_W-1:0] r_out_rgb [NCH];
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rgb  <= cv_rgb;
            r_out_last <= cv_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.red_out     = r_out_rgb[0];
    assign o_res.green_out   = r_out_rgb[1];
    assign o_res.blue_out    = r_out_rgb[2];
    assign o_res.last_result = r_out_last;

endmodule
